@@ rtl/csk_pkg.sv @@
// package: shared types, codes and the chord sequence table for the chord key decoder
package csk_pkg;

    // configuration register indexes
    localparam logic REG_CHORD_TIMEOUT    = 1'b0;
    localparam logic REG_MODIFIER_TIMEOUT = 1'b1;

    // register reset values
    localparam logic [15:0] CHORD_TIMEOUT_RST    = 16'd500;
    localparam logic [15:0] MODIFIER_TIMEOUT_RST = 16'd1000;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // chord that arms shift when it leads a sequence
    localparam logic [2:0] CHORD_ALL = 3'b111;

    // result event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_CHORD    = 3'd1;
    localparam logic [2:0] EV_KEY      = 3'd2;
    localparam logic [2:0] EV_DEAD     = 3'd3;
    localparam logic [2:0] EV_TIMEOUT  = 3'd4;
    localparam logic [2:0] EV_MODIFIER = 3'd5;
    localparam logic [2:0] EV_TOGGLE   = 3'd6;

    // table actions beyond the key codes
    localparam logic [6:0] ACT_NONE  = 7'd0;
    localparam logic [6:0] ACT_DEAD  = 7'd80;
    localparam logic [6:0] ACT_CTRL  = 7'd81;
    localparam logic [6:0] ACT_META  = 7'd82;
    localparam logic [6:0] ACT_ALT   = 7'd83;
    localparam logic [6:0] ACT_TECHO = 7'd84;
    localparam logic [6:0] ACT_TEMIT = 7'd85;

    // special key codes
    localparam logic [6:0] CODE_NONE      = 7'd0;
    localparam logic [6:0] CODE_CAPS      = 7'd73;
    localparam logic [6:0] CODE_LONE_META = 7'd74;

    // input transaction
    typedef struct packed {
        logic       opcode;
        logic [2:0] key_lines;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [2:0] event_res;
        logic [6:0] key_code;
        logic       with_ctrl;
        logic       with_shift;
        logic       with_alt;
        logic       with_meta;
        logic [2:0] finished_chord;
        logic       echo_mode;
        logic [2:0] lamp_chord;
    } t_out_item;

    // sequence to action map, one octal digit per chord, oldest first
    function automatic logic [6:0] seq_action(input logic [14:0] seq);
        logic [6:0] act;
        case (seq)
            15'o44: act = 7'd1;   15'o42: act = 7'd2;   15'o41: act = 7'd3;
            15'o46: act = 7'd4;   15'o43: act = 7'd5;   15'o45: act = 7'd6;
            15'o47: act = 7'd7;
            15'o24: act = 7'd8;   15'o22: act = 7'd9;   15'o21: act = 7'd10;
            15'o26: act = 7'd11;  15'o23: act = 7'd12;  15'o25: act = 7'd13;
            15'o27: act = 7'd14;
            15'o14: act = 7'd15;  15'o12: act = 7'd16;  15'o11: act = 7'd17;
            15'o16: act = 7'd18;  15'o13: act = 7'd19;  15'o15: act = 7'd20;
            15'o17: act = 7'd21;
            15'o54: act = 7'd22;  15'o52: act = 7'd23;  15'o51: act = 7'd24;
            15'o56: act = 7'd25;  15'o53: act = 7'd26;  15'o55: act = 7'd27;
            15'o57: act = 7'd28;
            15'o64: act = 7'd29;  15'o62: act = 7'd30;  15'o61: act = 7'd31;
            15'o66: act = 7'd32;  15'o63: act = 7'd33;  15'o65: act = 7'd34;
            15'o67: act = 7'd35;
            15'o34: act = 7'd36;  15'o32: act = 7'd37;  15'o31: act = 7'd38;
            15'o36: act = 7'd39;  15'o33: act = 7'd40;
            15'o354: act = 7'd41; 15'o352: act = 7'd42; 15'o351: act = 7'd43;
            15'o356: act = 7'd44; 15'o353: act = 7'd45; 15'o355: act = 7'd46;
            15'o357: act = 7'd47;
            15'o374: act = 7'd48; 15'o372: act = 7'd49; 15'o376: act = 7'd50;
            15'o373: act = 7'd51;
            15'o3774: act = 7'd52; 15'o3771: act = 7'd53; 15'o3776: act = 7'd54;
            15'o3773: act = 7'd55; 15'o3772: act = 7'd56; 15'o3775: act = 7'd57;
            15'o3754: act = 7'd58; 15'o3756: act = 7'd59; 15'o3753: act = 7'd60;
            15'o37144: act = 7'd61; 15'o37142: act = 7'd62; 15'o37141: act = 7'd63;
            15'o37146: act = 7'd64; 15'o37143: act = 7'd65; 15'o37145: act = 7'd66;
            15'o37147: act = 7'd67;
            15'o37114: act = 7'd68; 15'o37112: act = 7'd69; 15'o37111: act = 7'd70;
            15'o37116: act = 7'd71; 15'o37113: act = 7'd72;
            15'o3712, 15'o3716, 15'o3713, 15'o3715, 15'o3717: act = ACT_DEAD;
            15'o3777, 15'o3752, 15'o3751, 15'o3755, 15'o3757: act = ACT_DEAD;
            15'o37115, 15'o37117: act = ACT_DEAD;
            15'o74: act = ACT_CTRL;
            15'o72: act = ACT_META;
            15'o71: act = ACT_ALT;
            15'o76, 15'o73: act = ACT_DEAD;
            15'o77: act = CODE_CAPS;
            15'o754, 15'o752, 15'o751, 15'o755, 15'o757: act = ACT_DEAD;
            15'o756: act = ACT_TECHO;
            15'o753: act = ACT_TEMIT;
            default: act = ACT_NONE;
        endcase
        return act;
    endfunction

endpackage

@@ rtl/chord_sequence_key_decoder_unit.sv @@
// top level: three-button chord keyboard decoder with timeouts and apb configuration
//
// Each input transaction is either a key sample (opcode 0) or a one millisecond tick
// (opcode 1) and yields exactly one result transaction. Samples are ORed into a held
// chord that completes when all buttons read released; completed chords build a
// sequence of up to five chords that a fixed table maps to keys, modifiers, dead ends
// or mode toggles. The decode is a single table lookup between the state registers and
// the result register: one transaction is accepted per cycle and its result appears in
// the output register on the next cycle. The output register only blocks new input
// while it holds a result that the sink has not taken. Register 0 (byte address 0)
// holds the chord timeout in ticks, register 1 (byte address 4) the modifier timeout;
// write them only while the block is idle.
module chord_sequence_key_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csk_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output csk_pkg::t_out_item o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import csk_pkg::*;

    // configuration registers
    logic [15:0] r_chord_timeout;
    logic [15:0] r_modifier_timeout;

    // decoder state
    logic [2:0]  r_held;
    logic [14:0] r_seq;
    logic        r_shift, r_ctrl, r_alt, r_meta;
    logic        r_timer_run;
    logic [15:0] r_ticks;
    logic        r_echo, r_emit;

    logic [2:0]  n_held;
    logic [14:0] n_seq;
    logic        n_shift, n_ctrl, n_alt, n_meta;
    logic        n_timer_run;
    logic [15:0] n_ticks;
    logic        n_echo, n_emit;

    // result register
    logic        r_out_valid;
    t_out_item   r_out_data;
    t_out_item   n_out_data;

    // decode intermediates
    logic        accept;
    logic        cfg_write;
    logic [2:0]  held_or;
    logic [2:0]  chord;
    logic        chord_done;
    logic        arm_shift;
    logic [14:0] seq_shifted;
    logic [6:0]  act;

    // apb access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MODIFIER_TIMEOUT) ? {16'd0, r_modifier_timeout}
                                                          : {16'd0, r_chord_timeout};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord_timeout    <= CHORD_TIMEOUT_RST;
            r_modifier_timeout <= MODIFIER_TIMEOUT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_MODIFIER_TIMEOUT) begin
                r_modifier_timeout <= pwdata[15:0];
            end else begin
                r_chord_timeout <= pwdata[15:0];
            end
        end
    end

    // handshake: take input whenever the result register is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // chord completion and sequence lookup
    assign held_or     = r_held | i_in_data.key_lines;
    assign chord       = held_or;
    assign chord_done  = (i_in_data.opcode == OP_SAMPLE) && (i_in_data.key_lines == 3'd0)
                         && (held_or != 3'd0);
    assign arm_shift   = (r_seq == 15'd0) && !r_shift && (chord == CHORD_ALL);
    assign seq_shifted = arm_shift ? r_seq : {r_seq[11:0], chord};
    assign act         = seq_action(seq_shifted);

    // next state and result
    always_comb begin
        n_held      = r_held;
        n_seq       = r_seq;
        n_shift     = r_shift;
        n_ctrl      = r_ctrl;
        n_alt       = r_alt;
        n_meta      = r_meta;
        n_timer_run = r_timer_run;
        n_ticks     = r_ticks;
        n_echo      = r_echo;
        n_emit      = r_emit;

        n_out_data                = '0;
        n_out_data.event_res      = EV_NONE;
        n_out_data.key_code       = CODE_NONE;

        if (i_in_data.opcode == OP_TICK) begin
            // timer countdown and expiry
            if (r_timer_run) begin
                if (r_held == 3'd0 && r_ticks == 16'd0) begin
                    if (r_meta) begin
                        n_out_data.key_code = CODE_LONE_META;
                    end
                    n_out_data.event_res = EV_TIMEOUT;
                    n_shift     = 1'b0;
                    n_ctrl      = 1'b0;
                    n_alt       = 1'b0;
                    n_meta      = 1'b0;
                    n_seq       = '0;
                    n_timer_run = 1'b0;
                    n_ticks     = '0;
                end else if (r_ticks != 16'd0) begin
                    n_ticks = r_ticks - 16'd1;
                end
            end
        end else begin
            n_held = held_or;
            if (chord_done) begin
                n_out_data.finished_chord = chord;
                n_held = 3'd0;
                if (arm_shift) begin
                    n_shift = 1'b1;
                end
                n_seq = seq_shifted;
                case (act)
                    ACT_NONE: begin
                        n_out_data.event_res = EV_CHORD;
                        n_timer_run = 1'b1;
                        n_ticks     = r_chord_timeout;
                    end
                    ACT_CTRL, ACT_META, ACT_ALT: begin
                        if (act == ACT_CTRL) begin
                            n_ctrl = 1'b1;
                        end else if (act == ACT_META) begin
                            n_meta = 1'b1;
                        end else begin
                            n_alt = 1'b1;
                        end
                        n_shift     = 1'b0;
                        n_seq       = '0;
                        n_timer_run = 1'b1;
                        n_ticks     = r_modifier_timeout;
                        n_out_data.event_res = EV_MODIFIER;
                    end
                    ACT_TECHO, ACT_TEMIT, ACT_DEAD: begin
                        if (act == ACT_TECHO) begin
                            n_echo = !r_echo;
                        end else if (act == ACT_TEMIT) begin
                            n_emit = !r_emit;
                        end
                        n_out_data.event_res = (act == ACT_DEAD) ? EV_DEAD : EV_TOGGLE;
                        n_shift     = 1'b0;
                        n_ctrl      = 1'b0;
                        n_alt       = 1'b0;
                        n_meta      = 1'b0;
                        n_seq       = '0;
                        n_timer_run = 1'b0;
                        n_ticks     = '0;
                    end
                    default: begin
                        // key finished, caps lock drops shift first
                        if (r_emit) begin
                            n_out_data.key_code   = act;
                            n_out_data.with_ctrl  = r_ctrl;
                            n_out_data.with_shift = (act == CODE_CAPS) ? 1'b0
                                                                       : (r_shift || arm_shift);
                            n_out_data.with_alt   = r_alt;
                            n_out_data.with_meta  = r_meta;
                        end
                        n_out_data.event_res = EV_KEY;
                        n_shift     = 1'b0;
                        n_ctrl      = 1'b0;
                        n_alt       = 1'b0;
                        n_meta      = 1'b0;
                        n_seq       = '0;
                        n_timer_run = 1'b0;
                        n_ticks     = '0;
                    end
                endcase
            end
        end

        // status fields after this transaction
        n_out_data.echo_mode  = n_echo;
        n_out_data.lamp_chord = (n_held != 3'd0) ? n_held : n_seq[2:0];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_seq       <= '0;
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
            r_meta      <= 1'b0;
            r_timer_run <= 1'b0;
            r_ticks     <= '0;
            r_echo      <= 1'b0;
            r_emit      <= 1'b1;
        end else if (accept) begin
            r_held      <= n_held;
            r_seq       <= n_seq;
            r_shift     <= n_shift;
            r_ctrl      <= n_ctrl;
            r_alt       <= n_alt;
            r_meta      <= n_meta;
            r_timer_run <= n_timer_run;
            r_ticks     <= n_ticks;
            r_echo      <= n_echo;
            r_emit      <= n_emit;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ tb/sv/tb_csk_board_pkg.sv @@
// scoreboard for the chord key decoder: decode prediction and result comparison
package tb_csk_board_pkg;

    import csk_pkg::*;

    class key_event_board;

        // register copies
        bit [15:0] chord_limit;
        bit [15:0] modifier_limit;

        // decoder state copy
        bit [2:0]  held;
        bit [14:0] seq;
        bit        shift_on, ctrl_on, alt_on, meta_on;
        bit        timer_on;
        bit [15:0] ticks_left;
        bit        echo_on, emit_on;

        // predicted results, oldest first
        t_out_item due_events[$];

        int errors;
        int reports;
        int checked;
        int sent_items;
        int event_count[8];

        function new();
            chord_limit    = CHORD_TIMEOUT_RST;
            modifier_limit = MODIFIER_TIMEOUT_RST;
            held           = '0;
            drop_sequence();
            echo_on        = 1'b0;
            emit_on        = 1'b1;
        endfunction

        function void drop_sequence();
            shift_on   = 1'b0;
            ctrl_on    = 1'b0;
            alt_on     = 1'b0;
            meta_on    = 1'b0;
            seq        = '0;
            timer_on   = 1'b0;
            ticks_left = '0;
        endfunction

        function void set_limit(logic idx, bit [31:0] value);
            if (idx == REG_CHORD_TIMEOUT) begin
                chord_limit = value[15:0];
            end else begin
                modifier_limit = value[15:0];
            end
        endfunction

        // column of a chord in the letter grid: 4 2 1 6 3 5 7
        function int chord_col(bit [2:0] d);
            case (d)
                3'd4: return 0;
                3'd2: return 1;
                3'd1: return 2;
                3'd6: return 3;
                3'd3: return 4;
                3'd5: return 5;
                default: return 6;
            endcase
        endfunction

        // row of a leading chord in the letter grid: 4 2 1 5 6 3
        function int chord_row(bit [2:0] d);
            case (d)
                3'd4: return 0;
                3'd2: return 1;
                3'd1: return 2;
                3'd5: return 3;
                3'd6: return 4;
                default: return 5;
            endcase
        endfunction

        // what a chord sequence resolves to, ACT_NONE while still partial
        function bit [6:0] sequence_action(bit [14:0] s);
            bit [2:0] last;
            int       col;
            last = s[2:0];
            col  = chord_col(last);
            // two chords
            if (s[14:6] == 0 && s[5:3] != 0) begin
                if (s[5:3] != CHORD_ALL) begin
                    if (s[5:3] == 3'd3 && col > 4) return ACT_NONE;
                    return 7'(chord_row(s[5:3]) * 7 + col + 1);
                end
                case (last)
                    3'd4: return ACT_CTRL;
                    3'd2: return ACT_META;
                    3'd1: return ACT_ALT;
                    3'd7: return CODE_CAPS;
                    3'd5: return ACT_NONE;
                    default: return ACT_DEAD;
                endcase
            end
            // three chords
            if (s[14:9] == 0 && s[8:6] != 0) begin
                case (s[8:3])
                    6'o35: return 7'(41 + col);
                    6'o37: begin
                        case (last)
                            3'd4: return 7'd48;
                            3'd2: return 7'd49;
                            3'd6: return 7'd50;
                            3'd3: return 7'd51;
                            default: return ACT_NONE;
                        endcase
                    end
                    6'o75: begin
                        if (last == 3'd6) return ACT_TECHO;
                        if (last == 3'd3) return ACT_TEMIT;
                        return ACT_DEAD;
                    end
                    default: return ACT_NONE;
                endcase
            end
            // four chords
            if (s[14:12] == 0 && s[11:9] != 0) begin
                case (s[11:3])
                    9'o371: return (last == 3'd1 || last == 3'd4) ? ACT_NONE : ACT_DEAD;
                    9'o375: begin
                        case (last)
                            3'd4: return 7'd58;
                            3'd6: return 7'd59;
                            3'd3: return 7'd60;
                            default: return ACT_DEAD;
                        endcase
                    end
                    9'o377: begin
                        case (last)
                            3'd4: return 7'd52;
                            3'd1: return 7'd53;
                            3'd6: return 7'd54;
                            3'd3: return 7'd55;
                            3'd2: return 7'd56;
                            3'd5: return 7'd57;
                            default: return ACT_DEAD;
                        endcase
                    end
                    default: return ACT_NONE;
                endcase
            end
            // five chords
            if (s[14:12] != 0) begin
                case (s[14:3])
                    12'o3714: return 7'(61 + col);
                    12'o3711: return (col <= 4) ? 7'(68 + col) : ACT_DEAD;
                    default: return ACT_NONE;
                endcase
            end
            return ACT_NONE;
        endfunction

        // advance the state copy by one transaction and build its result
        function t_out_item predict_key_event(t_in_item it);
            t_out_item r;
            bit [2:0]  c;
            bit [6:0]  act;
            r = '0;
            if (it.opcode == OP_TICK) begin
                if (timer_on) begin
                    if (held == 0 && ticks_left == 0) begin
                        if (meta_on) r.key_code = CODE_LONE_META;
                        r.event_res = EV_TIMEOUT;
                        drop_sequence();
                    end else if (ticks_left > 0) begin
                        ticks_left--;
                    end
                end
            end else begin
                held = held | it.key_lines;
                if (it.key_lines == 0 && held != 0) begin
                    c = held;
                    r.finished_chord = c;
                    held = '0;
                    if (seq == 0 && !shift_on && c == CHORD_ALL) begin
                        shift_on = 1'b1;
                    end else begin
                        seq = {seq[11:0], c};
                    end
                    act = sequence_action(seq);
                    if (act == ACT_NONE) begin
                        r.event_res = EV_CHORD;
                        timer_on    = 1'b1;
                        ticks_left  = chord_limit;
                    end else if (act == ACT_CTRL || act == ACT_META || act == ACT_ALT) begin
                        if (act == ACT_CTRL) ctrl_on = 1'b1;
                        else if (act == ACT_META) meta_on = 1'b1;
                        else alt_on = 1'b1;
                        shift_on    = 1'b0;
                        seq         = '0;
                        timer_on    = 1'b1;
                        ticks_left  = modifier_limit;
                        r.event_res = EV_MODIFIER;
                    end else if (act == ACT_TECHO || act == ACT_TEMIT) begin
                        if (act == ACT_TECHO) echo_on = !echo_on;
                        else emit_on = !emit_on;
                        drop_sequence();
                        r.event_res = EV_TOGGLE;
                    end else if (act == ACT_DEAD) begin
                        drop_sequence();
                        r.event_res = EV_DEAD;
                    end else begin
                        // caps lock never carries shift
                        if (act == CODE_CAPS) shift_on = 1'b0;
                        if (emit_on) begin
                            r.key_code   = act;
                            r.with_ctrl  = ctrl_on;
                            r.with_shift = shift_on;
                            r.with_alt   = alt_on;
                            r.with_meta  = meta_on;
                        end
                        drop_sequence();
                        r.event_res = EV_KEY;
                    end
                end
            end
            r.echo_mode  = echo_on;
            r.lamp_chord = (held != 0) ? held : seq[2:0];
            return r;
        endfunction

        function void take_input(t_in_item it);
            t_out_item r;
            sent_items++;
            r = predict_key_event(it);
            event_count[r.event_res]++;
            due_events.insert(due_events.size(), r);
        endfunction

        function string fmt(t_out_item e);
            return $sformatf("ev=%0d key=%0d c/s/a/m=%0d%0d%0d%0d fin=%0d echo=%0d disp=%0d",
                             e.event_res, e.key_code, e.with_ctrl, e.with_shift, e.with_alt,
                             e.with_meta, e.finished_chord, e.echo_mode, e.lamp_chord);
        endfunction

        function void check_key_event(t_out_item got);
            t_out_item want;
            if (due_events.size() == 0) begin
                errors++;
                if (reports < 10) $display("unexpected result: %s", fmt(got));
                reports++;
                return;
            end
            want = due_events.pop_front();
            checked++;
            if (got.event_res !== want.event_res || got.key_code !== want.key_code ||
                got.with_ctrl !== want.with_ctrl || got.with_shift !== want.with_shift ||
                got.with_alt !== want.with_alt || got.with_meta !== want.with_meta ||
                got.finished_chord !== want.finished_chord ||
                got.echo_mode !== want.echo_mode ||
                got.lamp_chord !== want.lamp_chord) begin
                errors++;
                if (reports < 10) begin
                    $display("mismatch at result %0d: expected %s, got %s",
                             checked, fmt(want), fmt(got));
                end
                reports++;
            end
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        function void close();
            if (due_events.size() != 0) begin
                errors++;
                $display("%0d results never arrived", due_events.size());
            end
        endfunction

    endclass

endpackage

@@ tb/sv/tb_chord_sequence_key_decoder_unit.sv @@
// testbench top: random and directed chord traffic against the chord key decoder
module tb_chord_sequence_key_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import csk_pkg::*;
    import tb_csk_board_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    key_event_board board;

    // traffic control shared by the sender and the sink
    bit idle_on;
    int hold_asked;
    int hold_taken;
    int hold_left;
    int stall_left;
    int quiet_cycles;
    bit moved;

    // timeout settings per random phase, extremes included
    int chord_set    [PHASES] = '{3, 1, 65535, 2, 5, 1};
    int modifier_set [PHASES] = '{4, 1, 65535, 65535, 9, 3};

    // chord prefixes that lead deep into the table, empty ones for plain words
    bit [14:0] word_starts [13] = '{15'o0, 15'o0, 15'o3714, 15'o3711, 15'o377, 15'o375,
                                    15'o371, 15'o35, 15'o775, 15'o774, 15'o772, 15'o771,
                                    15'o77};

    chord_sequence_key_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // sink: long hold-off on request, random stall bursts otherwise
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                board.take_input(i_in_data);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                board.check_key_event(o_out_data);
                moved = 1'b1;
            end
            if (moved) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input bit [15:0] value);
        bit [31:0] word;
        // upper bits are junk the block must drop
        word = $urandom;
        word[15:0] = value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_limit(idx, word);
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input bit [2:0] lines);
        t_in_item it;
        it.opcode    = OP_SAMPLE;
        it.key_lines = lines;
        send_item(it);
    endtask

    // key lines carry junk on ticks
    task automatic send_tick();
        t_in_item it;
        it.opcode    = OP_TICK;
        it.key_lines = 3'($urandom);
        send_item(it);
    endtask

    task automatic send_noise();
        t_in_item it;
        it.opcode    = 1'($urandom);
        it.key_lines = 3'($urandom);
        send_item(it);
    endtask

    // press a chord in up to two partial samples and a full one, then release
    task automatic type_chord(input bit [2:0] c);
        bit [2:0] part;
        repeat ($urandom_range(0, 2)) begin
            part = c & 3'($urandom);
            if (part == 0) part = c;
            send_sample(part);
            if ($urandom_range(0, 15) == 0) send_tick();
        end
        send_sample(c);
        if ($urandom_range(0, 9) == 0) send_tick();
        send_sample(3'b000);
        if ($urandom_range(0, 11) == 0) send_sample(3'b000);
    endtask

    task automatic type_word();
        bit [14:0] start;
        bit [2:0]  d;
        if ($urandom_range(0, 4) == 0) type_chord(CHORD_ALL);
        start = word_starts[$urandom_range(0, 12)];
        for (int k = 4; k >= 0; k--) begin
            d = start[3*k +: 3];
            if (d != 0) type_chord(d);
        end
        repeat ((start == 0) ? 2 : 1) type_chord(3'($urandom_range(1, 7)));
    endtask

    // stop offering and wait until every predicted result is taken
    task automatic await_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        int quota;
        int pick;
        board = new();
        idle_on = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short timeouts so the directed part reaches expiry quickly
        write_reg(REG_CHORD_TIMEOUT, 16'd1);
        write_reg(REG_MODIFIER_TIMEOUT, 16'd2);

        // tick with no timer running
        send_tick();
        // leading all-button chord arms shift
        send_sample(3'b111);
        send_sample(3'b000);
        // chord built from two partial samples enters the sequence
        send_sample(3'b101);
        send_sample(3'b011);
        send_sample(3'b000);
        // meta armed
        send_sample(3'b010);
        send_sample(3'b000);
        // ticks while a chord is held run the count down but cannot fire
        send_sample(3'b001);
        repeat (3) send_tick();
        send_sample(3'b000);
        // expiry with meta armed gives the lone meta press
        repeat (2) send_tick();
        // caps lock drops shift
        repeat (3) type_chord(CHORD_ALL);
        // emission toggled off
        type_chord(CHORD_ALL);
        type_chord(CHORD_ALL);
        type_chord(3'b101);
        type_chord(3'b011);
        await_all_results();

        // random phases, each with its own timeout setting
        quota = board.sent_items;
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_CHORD_TIMEOUT, 16'(chord_set[p]));
            write_reg(REG_MODIFIER_TIMEOUT, 16'(modifier_set[p]));
            idle_on = (p != PHASES - 1);
            if (p == 1) begin
                // sink holds off while items keep coming, block backs up
                idle_on = 1'b0;
                hold_asked++;
                repeat (30) send_noise();
                idle_on = 1'b1;
            end
            quota += PHASE_ITEMS;
            while (board.sent_items < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    type_word();
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 8)) send_tick();
                end else begin
                    repeat ($urandom_range(1, 4)) send_noise();
                end
            end
            await_all_results();
        end

        board.close();
        $display("covered %0d results: %0d chords taken, %0d keys, %0d dead ends",
                 board.checked, board.event_count[EV_CHORD], board.event_count[EV_KEY],
                 board.event_count[EV_DEAD]);
        $display("%0d timeouts, %0d modifiers armed, %0d mode toggles, %0d errors",
                 board.event_count[EV_TIMEOUT], board.event_count[EV_MODIFIER],
                 board.event_count[EV_TOGGLE], board.errors);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/csk_pkg.sv
rtl/chord_sequence_key_decoder_unit.sv
tb/sv/tb_csk_board_pkg.sv
tb/sv/tb_chord_sequence_key_decoder_unit.sv
